/* rtl/mavg_pkg.sv */
// Shared constants and controller-to-datapath command type for the moving-average filter.
`default_nettype none

package mavg_pkg;

	localparam int DEF_MAX_WINDOW   = 64;
	localparam int DEF_SAMPLE_WIDTH = 16;
	localparam int CFG_W            = 7;
	localparam int LEN_RESET        = 8;

	typedef struct packed {
		logic accept;
		logic update;
		logic prep;
		logic step;
		logic load;
	} mavg_cmd_t;

endpackage

`default_nettype wire

/* rtl/mavg_datapath.sv */
// Datapath: history ring, running sum, fill count, bit-serial divider and output register.
`default_nettype none

module mavg_datapath import mavg_pkg::*; #(
	parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
	localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
	localparam int CNT_W = $clog2(MAX_WINDOW + 1),
	localparam int SUM_W = SAMPLE_WIDTH + $clog2(MAX_WINDOW)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_W-1:0]        cfg_wdata,
	input  wire mavg_cmd_t               cmd,
	input  wire logic [SAMPLE_WIDTH-1:0] sample,
	output logic      [SAMPLE_WIDTH-1:0] mean
);

	localparam logic [CFG_W-1:0] LEN_INIT =
		CFG_W'((LEN_RESET > MAX_WINDOW) ? MAX_WINDOW : LEN_RESET);

	logic signed [SAMPLE_WIDTH-1:0] mem [MAX_WINDOW];
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic signed [SAMPLE_WIDTH-1:0] old_q;
	logic                           old_valid_q;
	logic [PTR_W-1:0]               pos_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [CFG_W-1:0]               len_q;
	logic signed [SUM_W-1:0]        sum_q;
	logic [CFG_W-1:0]               rem_q;
	logic [SUM_W-1:0]               quo_q;
	logic                           neg_q;
	logic [SAMPLE_WIDTH-1:0]        mean_q;

	logic [CFG_W-1:0]               cfg_len;
	logic [PTR_W:0]                 back;
	logic [PTR_W-1:0]               old_pos;
	logic signed [SAMPLE_WIDTH-1:0] old_val;
	logic [CFG_W:0]                 cand;
	logic [CFG_W:0]                 diff;
	logic                           fits;
	logic [SUM_W-1:0]               quo_signed;

	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_len = CFG_W'(1);
		end else if (32'(cfg_wdata) > MAX_WINDOW) begin
			cfg_len = CFG_W'(MAX_WINDOW);
		end else begin
			cfg_len = cfg_wdata;
		end
	end

	always_comb begin
		back = {1'b0, pos_q} + (PTR_W+1)'(MAX_WINDOW) - (PTR_W+1)'(len_q);
		if (32'(back) >= MAX_WINDOW) begin
			old_pos = PTR_W'(back - (PTR_W+1)'(MAX_WINDOW));
		end else begin
			old_pos = back[PTR_W-1:0];
		end
	end

	assign old_val    = old_valid_q ? old_q : '0;
	assign cand       = {rem_q, quo_q[SUM_W-1]};
	assign fits       = cand >= {1'b0, len_q};
	assign diff       = cand - {1'b0, len_q};
	assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			mem[pos_q] <= sample_q;
		end
		if (cmd.accept) begin
			old_q <= mem[old_pos];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q    <= sample;
			old_valid_q <= 32'(cnt_q) >= 32'(len_q);
		end
		if (cmd.prep) begin
			neg_q <= sum_q[SUM_W-1];
			quo_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
			rem_q <= '0;
		end else if (cmd.step) begin
			rem_q <= fits ? diff[CFG_W-1:0] : cand[CFG_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
		if (cmd.load) begin
			mean_q <= quo_signed[SAMPLE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_INIT;
			pos_q <= '0;
			cnt_q <= '0;
			sum_q <= '0;
		end else if (cfg_we) begin
			len_q <= cfg_len;
			pos_q <= '0;
			cnt_q <= '0;
			sum_q <= '0;
		end else if (cmd.update) begin
			sum_q <= sum_q - SUM_W'(old_val) + SUM_W'(sample_q);
			pos_q <= (32'(pos_q) == MAX_WINDOW - 1) ? '0 : pos_q + 1'b1;
			if (32'(cnt_q) < MAX_WINDOW) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign mean = mean_q;

endmodule

`default_nettype wire

/* rtl/mavg_ctrl.sv */
// Controller: sequences request intake, sum update, serial divide and result handoff.
`default_nettype none

module mavg_ctrl import mavg_pkg::*; #(
	parameter int DIV_STEPS = DEF_SAMPLE_WIDTH + $clog2(DEF_MAX_WINDOW),
	localparam int STEP_W = $clog2(DIV_STEPS)
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output mavg_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_UPDATE = 3'd1;
	localparam logic [2:0] S_PREP   = 3'd2;
	localparam logic [2:0] S_DIV    = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == S_IDLE) && s_tvalid;
		cmd.update = state_q == S_UPDATE;
		cmd.prep   = state_q == S_PREP;
		cmd.step   = state_q == S_DIV;
		cmd.load   = (state_q == S_FINISH) && (!out_valid_q || m_tready);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: state_d = S_PREP;
			S_PREP:   state_d = S_DIV;
			S_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (cmd.load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = out_valid_q;

`ifndef SYNTH
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || m_tready))
		else $error("result overwrites an unread result");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !s_tready)
		else $error("new request taken while one is in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (step_q <= STEP_W'(DIV_STEPS - 1)))
		else $error("divide step count overran");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> (state_q == S_PREP) && !s_tready)
		else $error("sum update not followed by divider load");
`endif

endmodule

`default_nettype wire

/* rtl/moving_average_filter.sv */
// Top level of the boxcar moving-average filter.
// Sequence: a request accepted in IDLE passes UPDATE, PREP, DIV and FINISH; the restoring divider
//   forms one quotient bit per cycle of the SUM_W-bit sum, SUM_W = SAMPLE_WIDTH + clog2(MAX_WINDOW)
//   (22 at defaults). Only one request is in flight; FINISH loads the output register once any unread
//   result is taken, and that register lets the next request start while a result waits.
// Reset: arst_n clears control state, window_len to 8, sum and ring pointer; the history ring
//   is marked empty by a fill count, so no clearing pass is needed. Writing window_len clears the same datapath state.
`default_nettype none

module moving_average_filter import mavg_pkg::*; #(
	parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
	localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8,
	localparam int SUM_W   = SAMPLE_WIDTH + $clog2(MAX_WINDOW)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [CFG_W-1:0]   cfg_wdata,   // window_len
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [TDATA_W-1:0] s_tdata,     // sample
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic      [TDATA_W-1:0] m_tdata      // mean
);

	mavg_cmd_t               cmd;
	logic [SAMPLE_WIDTH-1:0] mean;

	mavg_ctrl #(
		.DIV_STEPS (SUM_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	mavg_datapath #(
		.MAX_WINDOW   (MAX_WINDOW),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sample    (s_tdata[SAMPLE_WIDTH-1:0]),
		.mean      (mean)
	);

	assign m_tdata = TDATA_W'(mean);

endmodule

`default_nettype wire
